// ===== rtl/sha2d_pkg.sv =====
// Package for the SHA-256/SHA-224 digest block: payload types, state enum,
// initial values, round constants and round helper functions. No dependencies.
`default_nettype none
package sha2d_pkg;

  localparam int WordW = 32;
  localparam int CountW = 61;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_FOLD,
    ST_PAD,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    FILL_MSG,
    FILL_PAD80,
    FILL_ZERO,
    FILL_LEN
  } fill_sel_t;

  typedef struct packed {
    logic       init;
    logic       store_wr;
    fill_sel_t  fill_sel;
    logic [5:0] store_addr;
    logic       load;
    logic       round;
    logic [5:0] round_idx;
    logic       fold;
    logic       count_inc;
  } dp_cmd_t;

  function automatic logic [31:0] iv_word(input logic mode, input logic [2:0] i);
    logic [31:0] r;
    if (!mode) begin
      case (i)
        3'd0: r = 32'h6a09e667;
        3'd1: r = 32'hbb67ae85;
        3'd2: r = 32'h3c6ef372;
        3'd3: r = 32'ha54ff53a;
        3'd4: r = 32'h510e527f;
        3'd5: r = 32'h9b05688c;
        3'd6: r = 32'h1f83d9ab;
        default: r = 32'h5be0cd19;
      endcase
    end else begin
      case (i)
        3'd0: r = 32'hc1059ed8;
        3'd1: r = 32'h367cd507;
        3'd2: r = 32'h3070dd17;
        3'd3: r = 32'hf70e5939;
        3'd4: r = 32'hffc00b31;
        3'd5: r = 32'h68581511;
        3'd6: r = 32'h64f98fa7;
        default: r = 32'hbefa4fa4;
      endcase
    end
    return r;
  endfunction

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage
`default_nettype wire

// ===== rtl/sha2d_ctrl.sv =====
// Controller for the SHA-256/SHA-224 digest block: sequences byte writes,
// compressions, padding and digest word output. Depends on sha2d_pkg.
`default_nettype none
module sha2d_ctrl
  import sha2d_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire in_item_t   in_item,
  input  wire logic [5:0] pos,
  input  wire logic       mode,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [2:0]      out_idx,
  output logic            out_last,
  output dp_cmd_t         cmd
);

  state_t     state_r, state_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic [5:0] pstart_r, pstart_nxt;
  logic [2:0] widx_r, widx_nxt;
  logic       mark_r, mark_nxt;
  logic       fin_r, fin_nxt;
  logic       pend_r, pend_nxt;
  logic       accept;
  logic       pad_end;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign out_idx  = widx_r;
  assign out_last = (widx_r == (mode ? 3'd6 : 3'd7));
  assign pad_end  = (cnt_r == 6'd63);

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    pstart_nxt = pstart_r;
    widx_nxt   = widx_r;
    mark_nxt   = mark_r;
    fin_nxt    = fin_r;
    pend_nxt   = pend_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_item.byte_present && pos == 6'd63) begin
            state_nxt = ST_LOAD;
            pend_nxt  = in_item.end_of_message;
            mark_nxt  = 1'b0;
            fin_nxt   = 1'b0;
          end else if (in_item.end_of_message) begin
            state_nxt  = ST_PAD;
            cnt_nxt    = in_item.byte_present ? pos + 6'd1 : pos;
            pstart_nxt = cnt_nxt;
            mark_nxt   = 1'b1;
            fin_nxt    = (cnt_nxt < 6'd56);
          end
        end
      end
      ST_LOAD: begin
        state_nxt = ST_ROUND;
        cnt_nxt   = 6'd0;
      end
      ST_ROUND: begin
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd63) state_nxt = ST_FOLD;
      end
      ST_FOLD: begin
        if (pend_r) begin
          state_nxt  = ST_PAD;
          cnt_nxt    = 6'd0;
          pstart_nxt = 6'd0;
          pend_nxt   = 1'b0;
          mark_nxt   = 1'b1;
          fin_nxt    = 1'b1;
        end else if (fin_r) begin
          state_nxt = ST_EMIT;
          widx_nxt  = 3'd0;
        end else if (mark_r) begin
          state_nxt = ST_PAD;
          cnt_nxt   = 6'd0;
          mark_nxt  = 1'b0;
          fin_nxt   = 1'b1;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_PAD: begin
        cnt_nxt = cnt_r + 6'd1;
        if (pad_end) state_nxt = ST_LOAD;
      end
      ST_EMIT: begin
        if (!out_stall) begin
          widx_nxt = widx_r + 3'd1;
          if (out_last) begin
            state_nxt = ST_IDLE;
            mark_nxt  = 1'b0;
            fin_nxt   = 1'b0;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.fill_sel   = FILL_MSG;
    cmd.store_addr = pos;
    cmd.round_idx  = cnt_r;
    case (state_r)
      ST_IDLE: begin
        cmd.store_wr  = accept && in_item.byte_present;
        cmd.count_inc = accept && in_item.byte_present;
      end
      ST_LOAD:  cmd.load = 1'b1;
      ST_ROUND: cmd.round = 1'b1;
      ST_FOLD: begin
        cmd.fold = 1'b1;
      end
      ST_PAD: begin
        cmd.store_wr   = 1'b1;
        cmd.store_addr = cnt_r;
        if (mark_r && cnt_r == pstart_r)
          cmd.fill_sel = FILL_PAD80;
        else if (fin_r && cnt_r >= 6'd56)
          cmd.fill_sel = FILL_LEN;
        else
          cmd.fill_sel = FILL_ZERO;
      end
      ST_EMIT: cmd.init = !out_stall && out_last;
      default: ;
    endcase
  end

  assign out_valid = (state_r == ST_EMIT);

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      state_r  <= ST_IDLE;
      cnt_r    <= '0;
      pstart_r <= '0;
      widx_r   <= '0;
      mark_r   <= 1'b0;
      fin_r    <= 1'b0;
      pend_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      pstart_r <= pstart_nxt;
      widx_r   <= widx_nxt;
      mark_r   <= mark_nxt;
      fin_r    <= fin_nxt;
      pend_r   <= pend_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/sha2d_dp.sv =====
// Datapath for the SHA-256/SHA-224 digest block: schedule window (which also
// gathers the block bytes), working words, chaining words and byte count. Depends on sha2d_pkg.
`default_nettype none
module sha2d_dp
  import sha2d_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic       cfg_mode,
  input  wire dp_cmd_t    cmd,
  input  wire logic [7:0] data_byte,
  input  wire logic [2:0] rd_idx,
  output logic [31:0]     rd_word,
  output logic [5:0]      pos,
  output logic            mode
);

  logic [31:0]       w_r [16];
  logic [31:0]       v_r [8];
  logic [31:0]       h_r [8];
  logic [CountW-1:0] count_r;
  logic              mode_r;
  logic [7:0]        wr_byte;
  logic [63:0]       bits;
  logic [31:0]       wnew, w_t, s0, s1, ch, maj, t1, t2, g0, g1;

  assign pos     = count_r[5:0];
  assign mode    = mode_r;
  assign rd_word = h_r[rd_idx];
  assign bits    = {count_r, 3'b000};

  always_comb begin
    case (cmd.fill_sel)
      FILL_MSG:   wr_byte = data_byte;
      FILL_PAD80: wr_byte = 8'h80;
      FILL_LEN:   wr_byte = bits[{~cmd.store_addr[2:0], 3'b000} +: 8];
      default:    wr_byte = 8'h00;
    endcase
  end

  assign g0   = rotr(w_r[1], 7) ^ rotr(w_r[1], 18) ^ (w_r[1] >> 3);
  assign g1   = rotr(w_r[14], 17) ^ rotr(w_r[14], 19) ^ (w_r[14] >> 10);
  assign wnew = w_r[0] + g0 + w_r[9] + g1;
  assign w_t  = (cmd.round_idx < 6'd16) ? w_r[cmd.round_idx[3:0]] : wnew;
  assign s1   = rotr(v_r[4], 6) ^ rotr(v_r[4], 11) ^ rotr(v_r[4], 25);
  assign ch   = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
  assign t1   = v_r[7] + s1 + ch + RoundK[cmd.round_idx] + w_t;
  assign s0   = rotr(v_r[0], 2) ^ rotr(v_r[0], 13) ^ rotr(v_r[0], 22);
  assign maj  = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
  assign t2   = s0 + maj;

  always_ff @(posedge clk) begin
    if (cmd.store_wr) begin
      w_r[cmd.store_addr[5:2]][{~cmd.store_addr[1:0], 3'b000} +: 8] <= wr_byte;
    end else if (cmd.round && cmd.round_idx >= 6'd16) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= wnew;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
    end else if (cmd.round) begin
      for (int i = 1; i < 8; i++) v_r[i] <= v_r[i-1];
      v_r[4] <= v_r[3] + t1;
      v_r[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we || cmd.init) begin
      for (int i = 0; i < 8; i++)
        h_r[i] <= iv_word(rst_n ? (cfg_we ? cfg_mode : mode_r) : 1'b0, 3'(i));
      count_r <= '0;
    end else begin
      if (cmd.fold)
        for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
      if (cmd.count_inc) count_r <= count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) mode_r <= 1'b0;
    else if (cfg_we) mode_r <= cfg_mode;
  end

endmodule
`default_nettype wire

// ===== rtl/sha256_sha224_digest.sv =====
// Top level of the SHA-256/SHA-224 digest block: joins controller and datapath.
// Depends on sha2d_pkg, sha2d_ctrl and sha2d_dp.
//
//   channel | ports                          | direction
//   in      | in_valid, in_stall, in_item    | bytes and end marker in
//   out     | out_valid, out_stall, out_item | digest words out
//   cfg     | cfg_we, cfg_digest_mode        | mode register write
//
// A byte that does not fill a block is taken without a stall. A byte that fills a block
// stalls the input through schedule load, 64 rounds and the chaining fold.
// End of message pads from the 0x80 offset to 63, then compresses; after a full block
// the 0x80 offset is 0. With 0x80 at offset 56 or above, a further pass and
// compression follow. Then 7 or 8 words, one a cycle while out_stall is low.
// Reset and mode writes restart.
`default_nettype none
module sha256_sha224_digest
  import sha2d_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      cfg_we,
  input  wire logic      cfg_digest_mode,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_item
);

  dp_cmd_t     cmd;
  logic [5:0]  pos;
  logic        mode;
  logic [2:0]  out_idx;
  logic        out_last;
  logic [31:0] rd_word;

  sha2d_ctrl u_ctrl (
    .clk, .rst_n, .cfg_we, .in_valid, .in_stall, .in_item, .pos, .mode,
    .out_valid, .out_stall, .out_idx, .out_last, .cmd
  );

  sha2d_dp u_dp (
    .clk, .rst_n, .cfg_we, .cfg_mode(cfg_digest_mode), .cmd,
    .data_byte(in_item.data_byte), .rd_idx(out_idx), .rd_word, .pos, .mode
  );

  assign out_item.digest_word = rd_word;
  assign out_item.word_index  = out_idx;
  assign out_item.last_word   = out_last;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input taken during output");
  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.last_word) |-> (out_item.word_index == 3'd6 ||
    out_item.word_index == 3'd7)) else $error("bad last word index");

endmodule
`default_nettype wire
